### hw/rtl/urtrb_pkg.sv
`timescale 1ns / 1ps
package urtrb_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [7:0]       byte_t;
  typedef logic [1:0]       func_t;

  localparam func_t FUNC_PUT  = 2'd0;
  localparam func_t FUNC_GET  = 2'd1;
  localparam func_t FUNC_RECV = 2'd2;

  localparam byte_t CH_CR = 8'h0D;
  localparam byte_t CH_LF = 8'h0A;

  function automatic ptr_t wrap_next(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

### hw/rtl/urtrb_if.sv
`timescale 1ns / 1ps
interface urtrb_in_if;
  logic                  valid;
  logic                  ready;
  urtrb_pkg::func_t      func;
  urtrb_pkg::byte_t      data;
  logic                  tx_ready;

  modport source (output valid, func, data, tx_ready, input ready);
  modport sink   (input valid, func, data, tx_ready, output ready);
endinterface

interface urtrb_out_if;
  logic                  valid;
  logic                  ready;
  logic                  tx_valid;
  urtrb_pkg::byte_t      tx_byte;
  urtrb_pkg::byte_t      read_byte;
  logic                  tx_irq_enable;
  logic                  rx_available;
  logic                  overflow;

  modport source (output valid, tx_valid, tx_byte, read_byte, tx_irq_enable,
                  rx_available, overflow, input ready);
  modport sink   (input valid, tx_valid, tx_byte, read_byte, tx_irq_enable,
                  rx_available, overflow, output ready);
endinterface

### hw/rtl/uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
// An accepted item moves to the execute state, and its result is registered
// when it commits there; the commit waits only while the previous result is
// still held on the output. A new item is taken only after the previous one
// commits, as the queue head bytes are read registered from the two store RAMs.
// Reset (rst, synchronous): clears the four queue pointers, the sequencer and
// the result valid flag; the store RAMs are not cleared.
module uart_rx_tx_ring_buffers (
  input  logic        clk,
  input  logic        rst,
  urtrb_in_if.sink    req,
  urtrb_out_if.source rsp
);
  import urtrb_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EXEC = 1'b1;

  logic [0:0] state;
  logic       accept;
  logic       commit;

  func_t item_func;
  byte_t item_data;
  logic  item_ready;

  ptr_t tx_write_ptr, tx_read_ptr, rx_write_ptr, rx_read_ptr;
  ptr_t tx_write_ptr_next, tx_read_ptr_next, rx_write_ptr_next, rx_read_ptr_next;

  logic  tx_we, rx_we;
  ptr_t  tx_waddr;
  byte_t tx_wdata, tx_head, rx_head;

  logic  is_put, is_lf, push1_ok, push2_ok, send, rx_ovf;
  ptr_t  wp1;
  byte_t first_byte, read_val;

  logic  out_valid;
  logic  out_tx_valid, out_tx_irq, out_rx_avail, out_ovf;
  byte_t out_tx_byte, out_read_byte;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign commit    = (state == S_EXEC) && (!out_valid || rsp.ready);

  // tx queue: first push, service, then the line feed push
  always_comb begin
    is_put     = (item_func == FUNC_PUT);
    is_lf      = is_put && (item_data == CH_LF);
    first_byte = is_lf ? CH_CR : item_data;
    push1_ok   = is_put && (wrap_next(tx_write_ptr) != tx_read_ptr);
    wp1        = push1_ok ? wrap_next(tx_write_ptr) : tx_write_ptr;
    send       = item_ready && (wp1 != tx_read_ptr);
    tx_read_ptr_next = send ? wrap_next(tx_read_ptr) : tx_read_ptr;
    push2_ok   = is_lf && (wrap_next(wp1) != tx_read_ptr_next);
    tx_write_ptr_next = push2_ok ? wrap_next(wp1) : wp1;
  end

  // rx queue
  always_comb begin
    rx_write_ptr_next = rx_write_ptr;
    rx_read_ptr_next  = rx_read_ptr;
    read_val          = '0;
    rx_ovf            = 1'b0;
    case (item_func)
      FUNC_GET: begin
        if (rx_write_ptr != rx_read_ptr) begin
          rx_read_ptr_next = wrap_next(rx_read_ptr);
          read_val         = (rx_head == CH_CR) ? CH_LF : rx_head;
        end
      end
      FUNC_RECV: begin
        // byte was written at accept; advance or flag the drop
        if (wrap_next(rx_write_ptr) != rx_read_ptr) begin
          rx_write_ptr_next = wrap_next(rx_write_ptr);
        end else begin
          rx_ovf = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // RAM write ports: first byte goes in at accept, line feed at commit
  always_comb begin
    if (state == S_IDLE) begin
      tx_we    = accept && (req.func == FUNC_PUT) &&
                 (wrap_next(tx_write_ptr) != tx_read_ptr);
      tx_waddr = tx_write_ptr;
      tx_wdata = (req.data == CH_LF) ? CH_CR : req.data;
    end else begin
      tx_we    = commit && push2_ok;
      tx_waddr = wp1;
      tx_wdata = CH_LF;
    end
    rx_we = accept && (req.func == FUNC_RECV) &&
            (wrap_next(rx_write_ptr) != rx_read_ptr);
  end

  urtrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .raddr (tx_read_ptr),
    .rdata (tx_head)
  );

  urtrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_write_ptr),
    .wdata (req.data),
    .raddr (rx_read_ptr),
    .rdata (rx_head)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      item_func  <= req.func;
      item_data  <= req.data;
      item_ready <= req.tx_ready;
    end
    if (commit) begin
      out_tx_valid  <= send;
      // bypass the RAM when the queue was empty before this item
      out_tx_byte   <= !send ? 8'h00 :
                       (tx_write_ptr == tx_read_ptr) ? first_byte : tx_head;
      out_read_byte <= read_val;
      out_tx_irq    <= (tx_write_ptr_next != tx_read_ptr_next);
      out_rx_avail  <= (rx_write_ptr_next != rx_read_ptr_next);
      out_ovf       <= rx_ovf || (is_put && (!push1_ok || (is_lf && !push2_ok)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      tx_write_ptr <= '0;
      tx_read_ptr  <= '0;
      rx_write_ptr <= '0;
      rx_read_ptr  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        out_valid    <= 1'b1;
        tx_write_ptr <= tx_write_ptr_next;
        tx_read_ptr  <= tx_read_ptr_next;
        rx_write_ptr <= rx_write_ptr_next;
        rx_read_ptr  <= rx_read_ptr_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.tx_valid      = out_tx_valid;
  assign rsp.tx_byte       = out_tx_byte;
  assign rsp.read_byte     = out_read_byte;
  assign rsp.tx_irq_enable = out_tx_irq;
  assign rsp.rx_available  = out_rx_avail;
  assign rsp.overflow      = out_ovf;

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted item did not enter execute");

  a_exec_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> !req.ready)
    else $error("input ready while an item is in execute");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> rsp.valid)
    else $error("committed item produced no result");

  a_send_pops: assert property (@(posedge clk) disable iff (rst)
    (commit && send) |=> (tx_read_ptr == wrap_next($past(tx_read_ptr))))
    else $error("sent byte did not advance the tx read pointer");
`endif

endmodule

### hw/rtl/urtrb_ram.sv
`timescale 1ns / 1ps
module urtrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/tb_uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
module tb_uart_rx_tx_ring_buffers;
  import urtrb_pkg::*;

  localparam func_t FUNC_TX_EVENT = 2'd3;
  localparam int    WATCHDOG_LIMIT = 5000;
  localparam int    DRAIN_CYCLES = 8;

  typedef struct packed {
    logic  tx_valid;
    byte_t tx_byte;
    byte_t read_byte;
    logic  tx_irq_enable;
    logic  rx_available;
    logic  overflow;
  } serial_result_t;

  logic clk;
  logic rst;

  urtrb_in_if  req_if ();
  urtrb_out_if rsp_if ();

  uart_rx_tx_ring_buffers dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  byte_t rx_ring [DEPTH];
  byte_t tx_ring [DEPTH];
  ptr_t  rx_head, rx_tail, tx_head, tx_tail;

  serial_result_t pending_results [$];
  serial_result_t want;
  int             mismatch_count;
  int             quiet_cycles;
  int             send_idle_pct;
  int             recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic ptr_t next_slot(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // Return 1 when the byte was stored, 0 when its ring was full.
  function automatic logic ring_push(logic to_tx, byte_t b);
    if (to_tx) begin
      if (next_slot(tx_tail) == tx_head) return 1'b0;
      tx_ring[tx_tail] = b;
      tx_tail = next_slot(tx_tail);
    end else begin
      if (next_slot(rx_tail) == rx_head) return 1'b0;
      rx_ring[rx_tail] = b;
      rx_tail = next_slot(rx_tail);
    end
    return 1'b1;
  endfunction

  // At most one byte leaves per item; the holding register reads busy after.
  function automatic void send_tx_byte(input logic rdy, inout serial_result_t r);
    if (rdy && !r.tx_valid && tx_tail != tx_head) begin
      r.tx_byte  = tx_ring[tx_head];
      tx_head    = next_slot(tx_head);
      r.tx_valid = 1'b1;
    end
  endfunction

  function automatic serial_result_t predict_serial_step(func_t f, byte_t d, logic rdy);
    serial_result_t r;
    byte_t          c;
    r = '0;
    case (f)
      FUNC_PUT: begin
        if (d == CH_LF) begin
          if (!ring_push(1'b1, CH_CR)) r.overflow = 1'b1;
          send_tx_byte(rdy, r);
        end
        if (!ring_push(1'b1, d)) r.overflow = 1'b1;
      end
      FUNC_GET: begin
        if (rx_tail != rx_head) begin
          c           = rx_ring[rx_head];
          rx_head     = next_slot(rx_head);
          r.read_byte = (c == CH_CR) ? CH_LF : c;
        end
      end
      FUNC_RECV: begin
        if (!ring_push(1'b0, d)) r.overflow = 1'b1;
      end
      default: ;
    endcase
    send_tx_byte(rdy, r);
    r.tx_irq_enable = (tx_tail != tx_head);
    r.rx_available  = (rx_tail != rx_head);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int exp_val);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
             exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
      rx_head = '0;
      rx_tail = '0;
      tx_head = '0;
      tx_tail = '0;
    end else begin
      if (req_if.valid && req_if.ready)
        pending_results.push_back(predict_serial_step(req_if.func, req_if.data,
                                                      req_if.tx_ready));
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", rsp_if.tx_valid, want.tx_valid);
          if (rsp_if.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", rsp_if.tx_byte, want.tx_byte);
          if (rsp_if.read_byte !== want.read_byte)
            report_mismatch("read_byte", rsp_if.read_byte, want.read_byte);
          if (rsp_if.tx_irq_enable !== want.tx_irq_enable)
            report_mismatch("tx_irq_enable", rsp_if.tx_irq_enable, want.tx_irq_enable);
          if (rsp_if.rx_available !== want.rx_available)
            report_mismatch("rx_available", rsp_if.rx_available, want.rx_available);
          if (rsp_if.overflow !== want.overflow)
            report_mismatch("overflow", rsp_if.overflow, want.overflow);
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(func_t f, byte_t d, logic rdy);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= f;
    req_if.data     <= d;
    req_if.tx_ready <= rdy;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Hold the sender until every pending result has come back.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(FUNC_GET, 8'hFF, 1'b1);
    send_item(FUNC_TX_EVENT, 8'h00, 1'b1);
    send_item(FUNC_RECV, 8'h00, 1'b0);
    send_item(FUNC_RECV, 8'hFF, 1'b1);
    send_item(FUNC_RECV, CH_CR, 1'b0);
    send_item(FUNC_RECV, CH_LF, 1'b0);
    send_item(FUNC_GET, 8'h55, 1'b0);
    send_item(FUNC_GET, 8'hAA, 1'b1);
    send_item(FUNC_GET, 8'h00, 1'b0);
    send_item(FUNC_GET, 8'hFF, 1'b0);
    send_item(FUNC_GET, 8'h00, 1'b1);
    send_item(FUNC_PUT, 8'h00, 1'b0);
    send_item(FUNC_PUT, 8'hFF, 1'b0);
    send_item(FUNC_PUT, CH_LF, 1'b0);
    send_item(FUNC_PUT, CH_LF, 1'b1);
    send_item(FUNC_PUT, CH_CR, 1'b1);
    send_item(FUNC_TX_EVENT, 8'hFF, 1'b0);
    repeat (6) send_item(FUNC_TX_EVENT, 8'hFF, 1'b1);
    send_item(FUNC_PUT, CH_LF, 1'b1);
    send_item(FUNC_TX_EVENT, 8'h00, 1'b1);
    wait_for_results();
  endtask

  task automatic test_full_rings();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_for_results();
    while (tx_tail != tx_head) begin
      send_item(FUNC_TX_EVENT, 8'h00, 1'b1);
      wait_for_results();
    end
    repeat (DEPTH) send_item(FUNC_RECV, byte_t'($urandom), 1'b0);
    repeat (DEPTH / 2) send_item(FUNC_PUT, CH_LF, 1'b0);
    send_item(FUNC_PUT, CH_LF, 1'b1);
    send_item(FUNC_RECV, CH_CR, 1'b1);
    send_item(FUNC_PUT, 8'h41, 1'b0);
    wait_for_results();
  endtask

  task automatic send_random_item();
    int    pick;
    func_t f;
    byte_t d;
    pick = $urandom_range(99);
    d    = byte_t'($urandom);
    if (pick < 28) begin
      f = FUNC_PUT;
      if ($urandom_range(5) == 0) d = CH_LF;
    end else if (pick < 60) begin
      f = FUNC_GET;
    end else if (pick < 85) begin
      f = FUNC_RECV;
      if ($urandom_range(5) == 0) d = CH_CR;
    end else begin
      f = FUNC_TX_EVENT;
    end
    send_item(f, d, ($urandom_range(99) < 55));
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_random_item();
      if ($urandom_range(99) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  initial begin
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.func     = FUNC_PUT;
    req_if.data     = 8'h00;
    req_if.tx_ready = 1'b0;
    mismatch_count  = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(0, 0, 40);
    test_random_traffic(64, 0, 40);
    test_random_traffic(0, 64, 40);
    test_random_traffic(7, 7, 40);
    test_full_rings();

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
